### hdl/ttt_pkg.sv
// shared types, constants and codes of the time triggered task table
package ttt_pkg;

  localparam int SLOTS   = 16;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MAX_OUT = 16;
  localparam int CNT_W   = $clog2(MAX_OUT + 1);
  localparam int CMP_W   = (IDX_W > 4) ? IDX_W : 4;

  typedef enum logic [1:0] {
    ACT_ADD  = 2'd0,
    ACT_DEL  = 2'd1,
    ACT_TICK = 2'd2,
    ACT_DISP = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic        used;
    logic [7:0]  task_id;
    logic [15:0] delay;
    logic [15:0] period;
    logic        ready;
  } slot_t;

endpackage

### hdl/ttt_if.sv
// valid/ready channel interfaces for commands and results
interface ttt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  task_id;
  logic [15:0] first_delay;
  logic [15:0] repeat_period;
  logic [3:0]  slot_sel;

  modport source (output valid, action, task_id, first_delay, repeat_period, slot_sel,
                  input ready);
  modport sink (input valid, action, task_id, first_delay, repeat_period, slot_sel,
                output ready);
endinterface

interface ttt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] slot_out;
  logic [7:0] run_task;
  logic       run_valid;
  logic       last;

  modport source (output valid, status, slot_out, run_task, run_valid, last, input ready);
  modport sink (input valid, status, slot_out, run_task, run_valid, last, output ready);
endinterface

### hdl/ttt_cell.sv
// one slot of the rotating task ring
module ttt_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  ttt_pkg::slot_t slot_i,
  output ttt_pkg::slot_t slot_o
);
  import ttt_pkg::*;

  slot_t slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (shift_i) begin
      slot_q <= slot_i;
    end
  end

  assign slot_o = slot_q;

endmodule

### hdl/ttt_ctrl.sv
// sequencer and head update of the task ring, with result buffering
module ttt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  ttt_in_if.sink         in_i,
  ttt_out_if.source      out_o,
  input  ttt_pkg::slot_t head_i,
  output logic           shift_o,
  output ttt_pkg::slot_t rec_o
);
  import ttt_pkg::*;

  state_e      state_q, state_d;
  action_e     act_q, act_d;
  logic [7:0]  tid_q, tid_d;
  logic [15:0] dly_q, dly_d;
  logic [15:0] per_q, per_d;
  logic [3:0]  sel_q, sel_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic        found_q, found_d;
  logic [3:0]  slot_q, slot_d;
  logic [CNT_W-1:0] n_q, n_d;

  logic        pend_valid_q, pend_valid_d;
  logic [3:0]  pend_slot_q, pend_slot_d;
  logic [7:0]  pend_task_q, pend_task_d;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  out_status_q, out_status_d;
  logic [3:0]  out_slot_q, out_slot_d;
  logic [7:0]  out_task_q, out_task_d;
  logic        out_run_q, out_run_d;
  logic        out_last_q, out_last_d;

  slot_t proc;
  logic  hit, stall, out_free;

  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d      = state_q;
    act_d        = act_q;
    tid_d        = tid_q;
    dly_d        = dly_q;
    per_d        = per_q;
    sel_d        = sel_q;
    idx_d        = idx_q;
    found_d      = found_q;
    slot_d       = slot_q;
    n_d          = n_q;
    pend_valid_d = pend_valid_q;
    pend_slot_d  = pend_slot_q;
    pend_task_d  = pend_task_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_task_d   = out_task_q;
    out_run_d    = out_run_q;
    out_last_d   = out_last_q;
    in_i.ready   = (state_q == S_IDLE);
    shift_o      = 1'b0;
    rec_o        = head_i;

    // update of the slot passing the head
    proc = head_i;
    hit  = 1'b0;
    unique case (act_q)
      ACT_ADD: begin
        if (!head_i.used && !found_q) begin
          proc = '{used: 1'b1, task_id: tid_q, delay: dly_q, period: per_q, ready: 1'b0};
        end
      end
      ACT_DEL: begin
        if (CMP_W'(idx_q) == CMP_W'(sel_q) && head_i.used) begin
          proc = '0;
        end
      end
      ACT_TICK: begin
        if (head_i.used) begin
          if (head_i.delay == 16'd0) begin
            proc.ready = 1'b1;
            if (head_i.period != 16'd0) begin
              proc.delay = head_i.period;
            end
          end else begin
            proc.delay = head_i.delay - 16'd1;
          end
        end
      end
      ACT_DISP: begin
        if (head_i.used && head_i.ready && n_q < CNT_W'(MAX_OUT)) begin
          hit        = 1'b1;
          proc.ready = 1'b0;
          if (head_i.period == 16'd0) begin
            proc = '0;
          end
        end
      end
      default: ;
    endcase
    // a new dispatch hit needs the held one to move on to the output register
    stall = hit && pend_valid_q && !out_free;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          act_d        = action_e'(in_i.action);
          tid_d        = in_i.task_id;
          dly_d        = in_i.first_delay;
          per_d        = in_i.repeat_period;
          sel_d        = in_i.slot_sel;
          idx_d        = '0;
          found_d      = 1'b0;
          slot_d       = 4'd0;
          n_d          = '0;
          pend_valid_d = 1'b0;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stall) begin
          shift_o = 1'b1;
          rec_o   = proc;
          if (act_q == ACT_ADD && !head_i.used && !found_q) begin
            found_d = 1'b1;
            slot_d  = 4'(idx_q);
          end
          if (act_q == ACT_DEL && CMP_W'(idx_q) == CMP_W'(sel_q) && head_i.used) begin
            found_d = 1'b1;
          end
          if (hit) begin
            n_d = n_q + CNT_W'(1);
            if (pend_valid_q) begin
              out_valid_d  = 1'b1;
              out_status_d = ST_OK;
              out_slot_d   = pend_slot_q;
              out_task_d   = pend_task_q;
              out_run_d    = 1'b1;
              out_last_d   = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_slot_d  = 4'(idx_q);
            pend_task_d  = head_i.task_id;
          end
          if (idx_q == IDX_W'(SLOTS - 1)) begin
            idx_d   = '0;
            state_d = S_FINISH;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_OK;
          out_slot_d   = 4'd0;
          out_task_d   = 8'd0;
          out_run_d    = 1'b0;
          out_last_d   = 1'b1;
          unique case (act_q)
            ACT_ADD: begin
              out_status_d = found_q ? ST_OK : ST_FULL;
              out_slot_d   = found_q ? slot_q : 4'd0;
            end
            ACT_DEL: begin
              out_status_d = found_q ? ST_OK : ST_EMPTY;
              out_slot_d   = sel_q;
            end
            ACT_DISP: begin
              if (pend_valid_q) begin
                out_slot_d = pend_slot_q;
                out_task_d = pend_task_q;
                out_run_d  = 1'b1;
              end
            end
            default: ;
          endcase
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      act_q        <= ACT_ADD;
      idx_q        <= '0;
      found_q      <= 1'b0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      act_q        <= act_d;
      idx_q        <= idx_d;
      found_q      <= found_d;
      n_q          <= n_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tid_q        <= tid_d;
    dly_q        <= dly_d;
    per_q        <= per_d;
    sel_q        <= sel_d;
    slot_q       <= slot_d;
    pend_slot_q  <= pend_slot_d;
    pend_task_q  <= pend_task_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_task_q   <= out_task_d;
    out_run_q    <= out_run_d;
    out_last_q   <= out_last_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_status_q;
  assign out_o.slot_out  = out_slot_q;
  assign out_o.run_task  = out_task_q;
  assign out_o.run_valid = out_run_q;
  assign out_o.last      = out_last_q;

endmodule

### hdl/time_triggered_task_table_top.sv
// top level of the time triggered task table: ring of slot cells and its sequencer
//
// The task slots sit in a ring of cells that rotates by one slot per cycle, unless
// stalled, past a single update point, so every command (add, delete, tick, dispatch)
// takes one full turn of the ring: an item is taken in the idle state, the ring then
// rotates through all SLOTS slots in the scan state, and the finish state forms the result.
// During a dispatch the ring pauses while a result waits for the output register to
// drain, so a stalled result sink lengthens the command. Results of one command come
// out in slot order, the final one marked with last. All slots are empty after reset.
module time_triggered_task_table_top (
  input logic       clk_i,
  input logic       rst_ni,
  ttt_in_if.sink    in_i,
  ttt_out_if.source out_o
);
  import ttt_pkg::*;

  slot_t chain [SLOTS];
  slot_t rec;
  logic  shift;

  ttt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .out_o   (out_o),
    .head_i  (chain[0]),
    .shift_o (shift),
    .rec_o   (rec)
  );

  // updated head slot re-enters at the tail
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    if (k == SLOTS - 1) begin : g_tail
      ttt_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .slot_i  (rec),
        .slot_o  (chain[k])
      );
    end else begin : g_body
      ttt_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .slot_i  (chain[k+1]),
        .slot_o  (chain[k])
      );
    end
  end

endmodule

### tb/tb_top.sv
// testbench of the time triggered task table: directed and random commands, slot mirror
module tb_top;
  import ttt_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 8;
  localparam int RAND_PER_PHASE = 30;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 4 * SLOTS;
  localparam int CYCLE_LIMIT    = 400_000;
  localparam int NUM_PHASES     = 4;

  // sender idle and receiver stall chances per phase, in percent
  localparam int SEND_IDLE [NUM_PHASES] = '{0, 51, 0, 27};
  localparam int RECV_STALL[NUM_PHASES] = '{0, 0, 51, 27};

  typedef struct {
    action_e     action;
    logic [7:0]  task_id;
    logic [15:0] first_delay;
    logic [15:0] repeat_period;
    logic [3:0]  slot_sel;
  } sched_cmd_t;

  typedef struct {
    status_e    status;
    logic [3:0] slot_out;
    logic [7:0] run_task;
    logic       run_valid;
    logic       last;
  } sched_res_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ttt_in_if  cmd_bus ();
  ttt_out_if res_bus ();

  time_triggered_task_table_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_bus),
    .out_o  (res_bus)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  sched_cmd_t cmd_backlog[$];
  sched_res_t due_results[$];
  slot_t      slot_mirror[SLOTS] = '{default: '0};

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int holds_asked   = 0;
  int holds_done;
  int hold_left;
  int mismatches    = 0;
  int cycle_count   = 0;

  // mirror of the slot table: updates it for one command and queues its results
  task automatic advance_table(input sched_cmd_t c);
    int free_idx;
    int found;
    free_idx = -1;
    found    = 0;
    case (c.action)
      ACT_ADD: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!slot_mirror[i].used && free_idx < 0) free_idx = i;
        end
        if (free_idx < 0) begin
          due_results.push_back('{ST_FULL, 4'd0, 8'd0, 1'b0, 1'b1});
        end else begin
          slot_mirror[free_idx].used    = 1'b1;
          slot_mirror[free_idx].task_id = c.task_id;
          slot_mirror[free_idx].delay   = c.first_delay;
          slot_mirror[free_idx].period  = c.repeat_period;
          slot_mirror[free_idx].ready   = 1'b0;
          due_results.push_back('{ST_OK, 4'(free_idx), 8'd0, 1'b0, 1'b1});
        end
      end
      ACT_DEL: begin
        if (int'(c.slot_sel) < SLOTS && slot_mirror[c.slot_sel].used) begin
          slot_mirror[c.slot_sel] = '0;
          due_results.push_back('{ST_OK, c.slot_sel, 8'd0, 1'b0, 1'b1});
        end else begin
          due_results.push_back('{ST_EMPTY, c.slot_sel, 8'd0, 1'b0, 1'b1});
        end
      end
      ACT_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_mirror[i].used) begin
            if (slot_mirror[i].delay == 16'd0) begin
              slot_mirror[i].ready = 1'b1;
              if (slot_mirror[i].period != 16'd0) slot_mirror[i].delay = slot_mirror[i].period;
            end else begin
              slot_mirror[i].delay = slot_mirror[i].delay - 16'd1;
            end
          end
        end
        due_results.push_back('{ST_OK, 4'd0, 8'd0, 1'b0, 1'b1});
      end
      default: begin
        for (int i = 0; i < SLOTS && found < MAX_OUT; i++) begin
          if (slot_mirror[i].used && slot_mirror[i].ready) begin
            due_results.push_back('{ST_OK, 4'(i), slot_mirror[i].task_id, 1'b1, 1'b0});
            found++;
            slot_mirror[i].ready = 1'b0;
            if (slot_mirror[i].period == 16'd0) slot_mirror[i] = '0;
          end
        end
        if (found == 0) begin
          due_results.push_back('{ST_OK, 4'd0, 8'd0, 1'b0, 1'b1});
        end else begin
          due_results[due_results.size() - 1].last = 1'b1;
        end
      end
    endcase
  endtask

  task automatic push_cmd(input action_e act, input logic [7:0] id, input logic [15:0] dly,
                          input logic [15:0] per, input logic [3:0] sel);
    sched_cmd_t c;
    c.action        = act;
    c.task_id       = id;
    c.first_delay   = dly;
    c.repeat_period = per;
    c.slot_sel      = sel;
    cmd_backlog.push_back(c);
  endtask

  // mostly short delays and periods so that ticks make tasks due; unused fields carry noise
  function automatic sched_cmd_t random_cmd();
    sched_cmd_t c;
    int pick;
    pick            = $urandom_range(99);
    c.task_id       = 8'($urandom_range(255));
    c.slot_sel      = 4'($urandom_range(15));
    c.first_delay   = ($urandom_range(99) < 70) ? 16'($urandom_range(3)) : 16'($urandom);
    pick            = $urandom_range(99);
    c.repeat_period = (pick < 40) ? 16'd0 :
                      (pick < 85) ? 16'($urandom_range(4, 1)) : 16'($urandom);
    pick            = $urandom_range(99);
    c.action        = (pick < 30) ? ACT_ADD :
                      (pick < 45) ? ACT_DEL :
                      (pick < 80) ? ACT_TICK : ACT_DISP;
    return c;
  endfunction

  task automatic wait_drained();
    do @(negedge clk_i);
    while (cmd_backlog.size() != 0 || cmd_bus.valid || due_results.size() != 0);
  endtask

  // command sender: predicts on each transfer, then offers the next command or idles
  always @(posedge clk_i or negedge rst_ni) begin : cmd_driver
    sched_cmd_t offered;
    sched_cmd_t nxt;
    if (!rst_ni) begin
      cmd_bus.valid         <= 1'b0;
      cmd_bus.action        <= ACT_ADD;
      cmd_bus.task_id       <= '0;
      cmd_bus.first_delay   <= '0;
      cmd_bus.repeat_period <= '0;
      cmd_bus.slot_sel      <= '0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        offered.action        = action_e'(cmd_bus.action);
        offered.task_id       = cmd_bus.task_id;
        offered.first_delay   = cmd_bus.first_delay;
        offered.repeat_period = cmd_bus.repeat_period;
        offered.slot_sel      = cmd_bus.slot_sel;
        advance_table(offered);
      end
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = cmd_backlog.pop_front();
          cmd_bus.valid         <= 1'b1;
          cmd_bus.action        <= nxt.action;
          cmd_bus.task_id       <= nxt.task_id;
          cmd_bus.first_delay   <= nxt.first_delay;
          cmd_bus.repeat_period <= nxt.repeat_period;
          cmd_bus.slot_sel      <= nxt.slot_sel;
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver: random stalls plus long hold-offs on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
      hold_left     <= 0;
      holds_done    <= 0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      res_bus.ready <= 1'b0;
    end else if (holds_done != holds_asked) begin
      hold_left     <= HOLD_CYCLES;
      holds_done    <= holds_done + 1;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_monitor
    sched_res_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (due_results.size() == 0) begin
        $error("result transfer with nothing due: slot_out %0d run_task %0d",
               res_bus.slot_out, res_bus.run_task);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (res_bus.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_bus.status);
          mismatches++;
        end
        if (res_bus.slot_out !== want.slot_out) begin
          $error("slot_out: expected %0d, got %0d", want.slot_out, res_bus.slot_out);
          mismatches++;
        end
        if (res_bus.run_task !== want.run_task) begin
          $error("run_task: expected %0d, got %0d", want.run_task, res_bus.run_task);
          mismatches++;
        end
        if (res_bus.run_valid !== want.run_valid) begin
          $error("run_valid: expected %0d, got %0d", want.run_valid, res_bus.run_valid);
          mismatches++;
        end
        if (res_bus.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, res_bus.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : sequencer
    int ph;
    int n;
    rst_ni = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // nothing due yet
    push_cmd(ACT_DISP, 8'h5a, 16'hffff, 16'hffff, 4'hf);
    // one-shot due at once, longest delay and period, periodic due at once
    push_cmd(ACT_ADD, 8'hff, 16'h0000, 16'h0000, 4'h0);
    push_cmd(ACT_ADD, 8'h00, 16'hffff, 16'hffff, 4'hf);
    push_cmd(ACT_ADD, 8'ha5, 16'h0000, 16'h0002, 4'h0);
    push_cmd(ACT_TICK, 8'h00, 16'h0000, 16'h0000, 4'h0);
    // one-shot slot 0 is freed, periodic slot 2 stays
    push_cmd(ACT_DISP, 8'h00, 16'h0000, 16'h0000, 4'h0);
    push_cmd(ACT_DEL, 8'h00, 16'h0000, 16'h0000, 4'd1);
    push_cmd(ACT_DEL, 8'hff, 16'hffff, 16'hffff, 4'd1);
    push_cmd(ACT_DEL, 8'h00, 16'h0000, 16'h0000, 4'd2);
    // fill the whole table, overflow it, then make every slot due at once
    for (n = 0; n < SLOTS; n++) push_cmd(ACT_ADD, 8'(n * 16 + 3), 16'd0, 16'd1, 4'(n));
    push_cmd(ACT_ADD, 8'h77, 16'd5, 16'd5, 4'h0);
    push_cmd(ACT_TICK, 8'h00, 16'h0000, 16'h0000, 4'h0);
    push_cmd(ACT_DISP, 8'h00, 16'h0000, 16'h0000, 4'h0);
    wait_drained();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct = SEND_IDLE[ph];
      stall_pct     = RECV_STALL[ph];
      // long receiver hold-off while commands keep coming, so the input backs up
      if (ph == 0) holds_asked = holds_asked + 1;
      for (n = 0; n < RAND_PER_PHASE; n++) cmd_backlog.push_back(random_cmd());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
